### hw/rtl/fn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer package
// Shared constants, register and mode codes, and the front-to-back control
// word of the feature normalizer.
// ----------------------------------------------------------------------------
package fn_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int ZCAP_INT  = 24;
  localparam int ZCAP_BITS = 5;

  localparam logic [30:0] LOG2E_Q = 31'd1549082005;
  localparam logic [29:0] LN2_Q   = 30'd744261118;

  localparam int TAYLOR_TERMS = 12;
  localparam int RECIP_SHIFT  = 34;
  localparam int RECIP_W      = 35;

  typedef logic [RECIP_W-1:0] recip_t;

  localparam recip_t RECIP [1:TAYLOR_TERMS] = '{
    35'(64'd17179869184 / 64'd1),
    35'(64'd17179869184 / 64'd2),
    35'(64'd17179869184 / 64'd3),
    35'(64'd17179869184 / 64'd4),
    35'(64'd17179869184 / 64'd5),
    35'(64'd17179869184 / 64'd6),
    35'(64'd17179869184 / 64'd7),
    35'(64'd17179869184 / 64'd8),
    35'(64'd17179869184 / 64'd9),
    35'(64'd17179869184 / 64'd10),
    35'(64'd17179869184 / 64'd11),
    35'(64'd17179869184 / 64'd12)
  };

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_LOW    = 3'd1,
    REG_HIGH   = 3'd2,
    REG_CENTER = 3'd3,
    REG_SPREAD = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_LINEAR   = 2'd0,
    MODE_SIGMOID  = 2'd1,
    MODE_DOUBLE   = 2'd2,
    MODE_STANDARD = 2'd3
  } norm_mode_e;

  typedef struct packed {
    logic sigm;
    logic neg;
    logic den_zero;
    logic num_zero;
    logic num_neg;
  } norm_ctrl_t;

endpackage

### hw/rtl/feature_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer
// Min-max, standardize, sigmoid and double-sigmoid normalization of signed
// fixed-point feature samples, with divide fault and saturation flags.
// ----------------------------------------------------------------------------
// Datapath: a result passes the quotient divider (one bit per stage),
//   the 36-stage Taylor pipeline and the reciprocal divider.
// Throughput: one sample per cycle unless out_ready stalls the back end;
//   a queue decouples front and back ends.
// Reset: synchronous; registers return to their reset values, queue and
//   pipeline empty, ready again on the next cycle.
module feature_normalizer #(
  parameter int FRAC_BITS    = fn_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_WIDTH = fn_pkg::SAMPLE_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = fn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [SAMPLE_WIDTH-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] sample_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] norm_value,
  output logic                    divide_fault,
  output logic                    clipped
);
  import fn_pkg::*;

  localparam int W      = SAMPLE_WIDTH;
  localparam int CTW    = $bits(norm_ctrl_t);
  localparam int DATA_W = CTW + 2 * W + 4;

  localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

  logic              q_full, q_push, q_pop, q_empty;
  norm_ctrl_t        f_ctrl, b_ctrl;
  logic [W+2:0]      f_nmag, b_nmag;
  logic [W:0]        f_dmag, b_dmag;
  logic [DATA_W-1:0] q_din, q_dout;

  fn_front #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_value(sample_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctrl      (f_ctrl),
    .q_nmag      (f_nmag),
    .q_dmag      (f_dmag)
  );

  assign q_din = {f_ctrl, f_nmag, f_dmag};

  fn_fifo #(
    .DATA_W(DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign {b_ctrl, b_nmag, b_dmag} = q_dout;

  fn_back #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctrl      (b_ctrl),
    .q_nmag      (b_nmag),
    .q_dmag      (b_dmag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .norm_value  (norm_value),
    .divide_fault(divide_fault),
    .clipped     (clipped)
  );

  a_clip_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> norm_value == Q_MAX || norm_value == Q_MIN)
    else $error("clipped result is not a saturation value");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("front end pushed into a full queue");

endmodule

### hw/rtl/fn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer front end
// Holds the configuration registers, accepts samples and turns each one into
// a numerator and divisor magnitude with a control word for the back end.
// ----------------------------------------------------------------------------
module fn_front #(
  parameter int FRAC_BITS    = fn_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_WIDTH = fn_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [SAMPLE_WIDTH-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] sample_value,
  input  logic                    q_full,
  output logic                    q_push,
  output fn_pkg::norm_ctrl_t      q_ctrl,
  output logic [SAMPLE_WIDTH+2:0] q_nmag,
  output logic [SAMPLE_WIDTH:0]   q_dmag
);
  import fn_pkg::*;

  localparam int W = SAMPLE_WIDTH;
  localparam logic [W-1:0] ONE_Q = SAMPLE_WIDTH'(1) << FRAC_BITS;

  norm_mode_e              norm_mode;
  logic signed [W-1:0]     low_bound, high_bound, center, spread;
  logic signed [W:0]       d_xl, d_hl, d_xc, d_cl, d_hc;
  logic signed [W+2:0]     num;
  logic signed [W:0]       den;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode  <= MODE_LINEAR;
      low_bound  <= '0;
      high_bound <= ONE_Q;
      center     <= '0;
      spread     <= ONE_Q;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_MODE:   norm_mode  <= norm_mode_e'(cfg_data[1:0]);
        REG_LOW:    low_bound  <= cfg_data;
        REG_HIGH:   high_bound <= cfg_data;
        REG_CENTER: center     <= cfg_data;
        REG_SPREAD: spread     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    d_xl = {sample_value[W-1], sample_value} - {low_bound[W-1], low_bound};
    d_hl = {high_bound[W-1], high_bound} - {low_bound[W-1], low_bound};
    d_xc = {sample_value[W-1], sample_value} - {center[W-1], center};
    d_cl = {center[W-1], center} - {low_bound[W-1], low_bound};
    d_hc = {high_bound[W-1], high_bound} - {center[W-1], center};
    num  = {{2{d_xl[W]}}, d_xl};
    den  = d_hl;
    unique case (norm_mode)
      MODE_LINEAR: begin
        num = {{2{d_xl[W]}}, d_xl};
        den = d_hl;
      end
      MODE_SIGMOID: begin
        num = {d_xc, 2'b00};
        den = d_hl;
      end
      MODE_DOUBLE: begin
        num = {d_xc[W], d_xc, 1'b0};
        den = d_xc[W] ? d_cl : d_hc;
      end
      MODE_STANDARD: begin
        num = {{2{d_xc[W]}}, d_xc};
        den = {spread[W-1], spread};
      end
    endcase
  end

  always_comb begin
    q_nmag          = num[W+2] ? (W+3)'(-num) : (W+3)'(num);
    q_dmag          = den[W] ? (W+1)'(-den) : (W+1)'(den);
    q_ctrl.sigm     = (norm_mode == MODE_SIGMOID) || (norm_mode == MODE_DOUBLE);
    q_ctrl.num_neg  = num[W+2];
    q_ctrl.num_zero = (num == '0);
    q_ctrl.den_zero = (den == '0);
    q_ctrl.neg      = num[W+2] ^ den[W];
  end

endmodule

### hw/rtl/fn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module fn_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = fn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/fn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer pipelined divider
// Restoring division, one quotient bit per stage, with a side word carried
// alongside each transaction.
// ----------------------------------------------------------------------------
module fn_div #(
  parameter int QN = 17,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QN-1:0] in_bits,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QN-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld [QN+1];
  logic [DW-1:0] rem [QN+1];
  logic [QN-1:0] quo [QN+1];
  logic [QN-1:0] bts [QN+1];
  logic [DW-1:0] dv  [QN+1];
  logic [SW-1:0] sd  [QN+1];

  assign vld[0] = in_valid;
  assign rem[0] = in_rem;
  assign quo[0] = '0;
  assign bts[0] = in_bits;
  assign dv[0]  = in_div;
  assign sd[0]  = in_side;

  for (genvar s = 1; s <= QN; s++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem[s-1], bts[s-1][QN-1]};
      ge    = (trial >= {1'b0, dv[s-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? DW'(trial - {1'b0, dv[s-1]}) : DW'(trial);
        quo[s] <= {quo[s-1][QN-2:0], ge};
        bts[s] <= bts[s-1] << 1;
        dv[s]  <= dv[s-1];
        sd[s]  <= sd[s-1];
      end
    end
  end

  assign out_valid = vld[QN];
  assign out_quo   = quo[QN];
  assign out_side  = sd[QN];

endmodule

### hw/rtl/fn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer back end
// Divides, evaluates the sigmoid through a Taylor pipeline and a second
// divider, saturates and drives the result register.
// ----------------------------------------------------------------------------
module fn_back #(
  parameter int FRAC_BITS    = fn_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_WIDTH = fn_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  fn_pkg::norm_ctrl_t      q_ctrl,
  input  logic [SAMPLE_WIDTH+2:0] q_nmag,
  input  logic [SAMPLE_WIDTH:0]   q_dmag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] norm_value,
  output logic                    divide_fault,
  output logic                    clipped
);
  import fn_pkg::*;

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int SH  = W + 1 - F;
  localparam int AW  = F + ZCAP_BITS;
  localparam int NT  = 3 * TAYLOR_TERMS;
  localparam int CTW = $bits(norm_ctrl_t);

  localparam logic [W:0]    ZCAP_Q  = (SAMPLE_WIDTH+1)'(ZCAP_INT) << F;
  localparam logic [AW-1:0] ZCAP_A  = AW'(ZCAP_INT) << F;
  localparam logic [W:0]    NEG_CAP = (SAMPLE_WIDTH+1)'(1) << (W - 1);
  localparam logic [W:0]    POS_CAP = ((SAMPLE_WIDTH+1)'(1) << (W - 1)) - 1'b1;
  localparam logic [W-1:0]  Q_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  Q_MIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [F:0]    ONE_S   = (FRAC_BITS+1)'(1) << F;

  typedef struct packed {
    logic         sigm;
    logic         fault;
    logic         clip;
    logic [W-1:0] val;
    logic         zneg;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic               big;
    logic [5:0]         k;
    logic [29:0]        g;
    logic [30:0]        t;
    logic signed [32:0] sum;
    logic [29:0]        p;
    logic [29:0]        qe;
  } tay_t;

  logic adv;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // precheck stage
  logic       p0_valid, p0_over;
  norm_ctrl_t p0_ctrl;
  logic [W:0] p0_rem, p0_bits, p0_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (adv) begin
      p0_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_ctrl <= q_ctrl;
      p0_over <= ({{SH{1'b0}}, q_nmag} >= {2'b00, q_dmag, {SH{1'b0}}});
      p0_rem  <= (SAMPLE_WIDTH+1)'(q_nmag >> SH);
      p0_bits <= {q_nmag[W-F:0], {F{1'b0}}};
      p0_div  <= q_dmag;
    end
  end

  // quotient divider
  logic           d1_valid;
  logic [W:0]     d1_quo;
  logic [CTW:0]   d1_side;
  norm_ctrl_t     d1_ctrl;
  logic           d1_over0;

  fn_div #(
    .QN (W + 1),
    .DW (W + 1),
    .SW (CTW + 1)
  ) u_div_q (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (p0_valid),
    .in_rem   (p0_rem),
    .in_bits  (p0_bits),
    .in_div   (p0_div),
    .in_side  ({p0_ctrl, p0_over}),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  assign {d1_ctrl, d1_over0} = d1_side;

  // cap, sign and zero divisor handling
  logic [W:0]    cap, qc;
  logic          over;
  side_t         r_nxt;
  logic [AW-1:0] a_nxt;
  logic          r_valid;
  side_t         r_side;
  logic [AW-1:0] r_a;

  always_comb begin
    cap = d1_ctrl.sigm ? ZCAP_Q : (d1_ctrl.neg ? NEG_CAP : POS_CAP);
    over = d1_over0 || (d1_quo > cap);
    qc = over ? cap : d1_quo;
    r_nxt.sigm  = d1_ctrl.sigm;
    r_nxt.fault = d1_ctrl.den_zero;
    r_nxt.clip  = 1'b0;
    r_nxt.val   = '0;
    r_nxt.zneg  = 1'b0;
    a_nxt       = '0;
    if (!d1_ctrl.sigm) begin
      if (d1_ctrl.den_zero) begin
        r_nxt.clip = !d1_ctrl.num_zero;
        r_nxt.val  = d1_ctrl.num_zero ? '0 : (d1_ctrl.num_neg ? Q_MIN : Q_MAX);
      end else begin
        r_nxt.clip = over;
        r_nxt.val  = d1_ctrl.neg ? SAMPLE_WIDTH'((~qc) + 1'b1) : SAMPLE_WIDTH'(qc);
      end
    end else if (d1_ctrl.den_zero) begin
      a_nxt      = d1_ctrl.num_zero ? '0 : ZCAP_A;
      r_nxt.zneg = d1_ctrl.num_neg;
    end else begin
      a_nxt      = qc[AW-1:0];
      r_nxt.zneg = d1_ctrl.neg && (qc != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_side <= r_nxt;
      r_a    <= a_nxt;
    end
  end

  // exponent split: y = a*log2(e), then g = frac(y)*ln2
  logic [AW+30:0] m_y;
  logic [35:0]    y;
  logic           s1_valid, s1_big;
  side_t          s1_side;
  logic [5:0]     s1_k;
  logic [29:0]    s1_f;
  logic [59:0]    m_g;

  assign m_y = (AW+31)'(r_a) * (AW+31)'(LOG2E_Q);
  assign y   = m_y[F+35:F];
  assign m_g = 60'(s1_f) * 60'(LN2_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= r_side;
      s1_big  <= (r_a >= ZCAP_A);
      s1_k    <= y[35:30];
      s1_f    <= y[29:0];
    end
  end

  // Taylor series of exp(-g): three stages per term
  tay_t ts [NT+1];
  logic tv [NT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (adv) begin
      tv[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ts[0].sd  <= s1_side;
      ts[0].big <= s1_big;
      ts[0].k   <= s1_k;
      ts[0].g   <= m_g[59:30];
      ts[0].t   <= 31'(1) << 30;
      ts[0].sum <= 33'(1) << 30;
      ts[0].p   <= '0;
      ts[0].qe  <= '0;
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_tay
    localparam int N  = j / 3 + 1;
    localparam int PH = j % 3;
    tay_t nxt;

    if (PH == 0) begin : g_mul
      logic [60:0] m_tg;
      always_comb begin
        m_tg  = 61'(ts[j].t) * 61'(ts[j].g);
        nxt   = ts[j];
        nxt.p = m_tg[59:30];
      end
    end else if (PH == 1) begin : g_rcp
      logic [64:0] m_rc;
      always_comb begin
        m_rc   = 65'(ts[j].p) * 65'(RECIP[N]);
        nxt    = ts[j];
        nxt.qe = m_rc[RECIP_SHIFT+29:RECIP_SHIFT];
      end
    end else begin : g_acc
      logic [33:0] rq;
      logic [29:0] qn;
      always_comb begin
        rq    = 34'(ts[j].p) - 34'(ts[j].qe) * 34'(N);
        qn    = ts[j].qe + 30'(rq >= 34'(N));
        nxt   = ts[j];
        nxt.t = {1'b0, qn};
        if ((N % 2) == 1) begin
          nxt.sum = ts[j].sum - $signed({3'b000, qn});
        end else begin
          nxt.sum = ts[j].sum + $signed({3'b000, qn});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tv[j+1] <= 1'b0;
      end else if (adv) begin
        tv[j+1] <= tv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ts[j+1] <= nxt;
      end
    end
  end

  // scale by 2^-k and form the rounded reciprocal operands
  logic [31:0]  sumc, e_val, den_v;
  logic [F+30:0] n2_v;
  logic          se_valid;
  side_t         se_side;
  logic [31:0]   se_den;
  logic [F+30:0] se_n2;

  always_comb begin
    sumc  = ts[NT].sum[32] ? '0 : ts[NT].sum[31:0];
    e_val = ts[NT].big ? '0 : (sumc >> ts[NT].k);
    den_v = (32'(1) << 30) + e_val;
    n2_v  = ((FRAC_BITS+31)'(1) << (F + 30)) + (FRAC_BITS+31)'(den_v >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else if (adv) begin
      se_valid <= tv[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_side <= ts[NT].sd;
      se_den  <= den_v;
      se_n2   <= n2_v;
    end
  end

  // reciprocal divider
  logic  d2_valid;
  logic [F:0] d2_quo;
  side_t d2_side;

  fn_div #(
    .QN (F + 1),
    .DW (32),
    .SW ($bits(side_t))
  ) u_div_s (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (se_valid),
    .in_rem   (32'(se_n2 >> (F + 1))),
    .in_bits  (se_n2[F:0]),
    .in_div   (se_den),
    .in_side  (se_side),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // result register
  logic [F:0]   rv;
  logic [W-1:0] rvw;

  always_comb begin
    rv  = d2_side.zneg ? (ONE_S - d2_quo) : d2_quo;
    rvw = SAMPLE_WIDTH'(rv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      divide_fault <= d2_side.fault;
      if (d2_side.sigm) begin
        norm_value <= rvw[W-1] ? Q_MAX : rvw;
        clipped    <= rvw[W-1];
      end else begin
        norm_value <= d2_side.val;
        clipped    <= d2_side.clip;
      end
    end
  end

endmodule

### sim/feature_normalizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature normalizer testbench
// Drives samples through every normalization mode under several register
// settings, predicts each normalized sample in fixed point, and compares
// value, divide fault and clip flags with random stalls on both channels.
// ----------------------------------------------------------------------------
module feature_normalizer_test;
  import fn_pkg::*;

  localparam int FB = 16;
  localparam int SW = 32;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint ZCAP_Q = 64'sd24 << FB;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM = 1650;

  typedef struct packed {
    logic [SW-1:0] value;
    logic          fault;
    logic          clip;
  } norm_result_t;

  typedef struct {
    logic [SW-1:0] sample;
    logic          known;
    norm_result_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [SW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SW-1:0] sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SW-1:0] norm_value;
  logic divide_fault;
  logic clipped;

  norm_result_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int faults_seen = 0;
  int clips_seen = 0;
  int modes_seen = 0;
  longint cycles = 0;
  logic calm = 1'b0;

  norm_mode_e mode_r;
  longint low_r, high_r, center_r, spread_r;

  always #6 clk = ~clk;

  feature_normalizer u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .norm_value(norm_value), .divide_fault(divide_fault), .clipped(clipped)
  );

  function automatic longint sx(logic [SW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned frac_quot(longint unsigned n, longint unsigned d,
                                                longint unsigned cap, ref bit over);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > (cap >> FB)) begin
      over = 1'b1;
      return cap;
    end
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    if (q > cap) begin
      over = 1'b1;
      return cap;
    end
    return q;
  endfunction

  function automatic longint signed_quot(longint n, longint d, ref bit fault, ref bit clip);
    bit neg, over;
    longint unsigned m;
    neg = (n < 0) != (d < 0);
    over = 1'b0;
    if (d == 0) begin
      fault = 1'b1;
      if (n == 0) return 0;
      clip = 1'b1;
      return n > 0 ? SMAX : SMIN;
    end
    m = frac_quot(absval(n), absval(d), neg ? 64'd2147483648 : 64'd2147483647, over);
    if (over) clip = 1'b1;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint logistic(longint z);
    longint unsigned a, e, y, k, f, g, t, den, sp;
    longint sum;
    a = absval(z);
    e = 0;
    if (a < ZCAP_Q) begin
      y = (a * 64'd1549082005) >> FB;
      k = y >> 30;
      f = y & ((64'd1 << 30) - 1);
      g = (f * 64'd744261118) >> 30;
      t = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        t = ((t * g) >> 30) / n;
        if (n % 2 == 1) sum -= longint'(t);
        else sum += longint'(t);
      end
      if (sum < 0) sum = 0;
      e = (k < 63) ? (longint'(sum) >> k) : 0;
    end
    den = (64'd1 << 30) + e;
    sp = ((64'd1 << (FB + 30)) + den / 2) / den;
    if (z < 0) sp = (64'd1 << FB) - sp;
    return longint'(sp);
  endfunction

  function automatic norm_result_t normalize(logic [SW-1:0] sample);
    norm_result_t res;
    longint x, r, num, den, z;
    bit fault, clip, over;
    longint unsigned m;
    x = sx(sample);
    fault = 1'b0;
    clip = 1'b0;
    over = 1'b0;
    case (mode_r)
      MODE_LINEAR: r = signed_quot(x - low_r, high_r - low_r, fault, clip);
      MODE_STANDARD: r = signed_quot(x - center_r, spread_r, fault, clip);
      default: begin
        if (mode_r == MODE_SIGMOID) begin
          num = 4 * (x - center_r);
          den = high_r - low_r;
        end else begin
          num = 2 * (x - center_r);
          den = (x < center_r) ? center_r - low_r : high_r - center_r;
        end
        if (den == 0) begin
          fault = 1'b1;
          z = num > 0 ? ZCAP_Q : (num < 0 ? -ZCAP_Q : 0);
        end else begin
          m = frac_quot(absval(num), absval(den), ZCAP_Q, over);
          z = ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
        end
        r = logistic(z);
        if (r > SMAX) begin
          r = SMAX;
          clip = 1'b1;
        end
      end
    endcase
    res.value = r[SW-1:0];
    res.fault = fault;
    res.clip = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [SW-1:0] data);
    if (expected_q.size() != 0 || in_valid) drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE: mode_r = norm_mode_e'(data[1:0]);
      REG_LOW: low_r = sx(data);
      REG_HIGH: high_r = sx(data);
      REG_CENTER: center_r = sx(data);
      default: spread_r = sx(data);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(logic [SW-1:0] s, bit check_known, norm_result_t known);
    norm_result_t pred;
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pred = normalize(s);
    if (check_known && pred !== known)
      report_mismatch("table", pred, known);
    in_valid <= 1'b1;
    sample_value <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(pred);
    @(negedge clk);
  endtask

  task automatic set_all(norm_mode_e m, logic [SW-1:0] lo, logic [SW-1:0] hi,
                         logic [SW-1:0] c, logic [SW-1:0] sp);
    drain();
    write_reg(REG_MODE, SW'(m));
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_CENTER, c);
    write_reg(REG_SPREAD, sp);
    modes_seen++;
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3) : 32'h80000000 + $urandom_range(3);
      default: return SW'(sx(SW'($urandom_range(65535) << $urandom_range(8))) - (1 << 20)
                          + ($urandom_range(1) ? center_r : low_r));
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", norm_value, 0);
      end else begin
        norm_result_t want;
        want = expected_q.pop_front();
        if (norm_value !== want.value) report_mismatch("norm_value", norm_value, want.value);
        if (divide_fault !== want.fault) report_mismatch("divide_fault", divide_fault, want.fault);
        if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
        checked++;
        faults_seen += divide_fault;
        clips_seen += clipped;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    norm_mode_e m;
    mode_r = MODE_LINEAR;
    low_r = 0;
    high_r = 64'sd1 << FB;
    center_r = 0;
    spread_r = 64'sd1 << FB;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: linear over [0, 1.0]
    rows.push_back('{32'h00000000, 1'b1, '{32'h00000000, 1'b0, 1'b0}});
    rows.push_back('{32'h00010000, 1'b1, '{32'h00010000, 1'b0, 1'b0}});
    rows.push_back('{32'h00008000, 1'b1, '{32'h00008000, 1'b0, 1'b0}});
    rows.push_back('{32'h7fffffff, 1'b1, '{32'h7fffffff, 1'b0, 1'b0}});
    rows.push_back('{32'h80000000, 1'b1, '{32'h80000000, 1'b0, 1'b0}});
    rows.push_back('{32'hffffffff, 1'b1, '{32'hffffffff, 1'b0, 1'b0}});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].res);

    // zero divisor in linear mode
    set_all(MODE_LINEAR, 32'h00010000, 32'h00010000, 0, 32'h00010000);
    send_sample(32'h00020000, 1'b1, '{32'h7fffffff, 1'b1, 1'b1});
    send_sample(32'h00000000, 1'b1, '{32'h80000000, 1'b1, 1'b1});
    send_sample(32'h00010000, 1'b1, '{32'h00000000, 1'b1, 1'b0});

    // standardize: zero spread and tiny spread overflow
    set_all(MODE_STANDARD, 0, 0, 32'h00010000, 0);
    send_sample(32'h00020000, 1'b1, '{32'h7fffffff, 1'b1, 1'b1});
    send_sample(32'h00010000, 1'b1, '{32'h00000000, 1'b1, 1'b0});
    write_reg(REG_SPREAD, 32'h00000001);
    send_sample(32'h7fffffff, 1'b1, '{32'h7fffffff, 1'b0, 1'b1});
    send_sample(32'h80000000, 1'b1, '{32'h80000000, 1'b0, 1'b1});
    write_reg(REG_SPREAD, 32'h80000000);
    send_sample(32'h00030000, 1'b0, '{default: '0});

    // sigmoid: center gives 0.5, zero alpha saturates z
    set_all(MODE_SIGMOID, 32'hfffe0000, 32'h00020000, 0, 32'h00010000);
    send_sample(32'h00000000, 1'b1, '{32'h00008000, 1'b0, 1'b0});
    send_sample(32'h7fffffff, 1'b1, '{32'h00010000, 1'b0, 1'b0});
    send_sample(32'h80000000, 1'b1, '{32'h00000000, 1'b0, 1'b0});
    write_reg(REG_HIGH, 32'hfffe0000);
    send_sample(32'h00000100, 1'b1, '{32'h00010000, 1'b1, 1'b0});
    send_sample(32'h00000000, 1'b1, '{32'h00008000, 1'b1, 1'b0});

    // double sigmoid: asymmetric halves and a zero half
    set_all(MODE_DOUBLE, 32'hffff0000, 32'h00040000, 32'hffff0000, 32'h00010000);
    send_sample(32'hfffe0000, 1'b0, '{default: '0});
    send_sample(32'h00010000, 1'b0, '{default: '0});
    send_sample(32'hffff0000, 1'b1, '{32'h00008000, 1'b0, 1'b0});

    // random phases, settings swept including extremes
    for (int ph = 0; ph < 11; ph++) begin
      m = norm_mode_e'(ph % 4);
      case (ph)
        4: set_all(m, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        5: set_all(m, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        6: set_all(m, $urandom(), $urandom(), $urandom(), $urandom());
        default: begin
          logic [SW-1:0] lo;
          lo = SW'(-int'($urandom_range(1 << 22)));
          set_all(m, lo, lo + $urandom_range(1 << 23), lo + $urandom_range(1 << 22),
                  $urandom_range(1) ? $urandom_range(1 << 20) : -$urandom_range(1 << 20));
        end
      endcase
      calm = (ph == 7);
      for (int i = 0; i < N_RANDOM / 11; i++) send_sample(rand_sample(), 1'b0, '{default: '0});
      calm = 1'b0;
    end

    drain();
    $display("checked %0d transactions over %0d register settings", checked, modes_seen);
    $display("divide faults %0d, clipped %0d", faults_seen, clips_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### feature_normalizer.f
hw/rtl/fn_pkg.sv
hw/rtl/fn_front.sv
hw/rtl/fn_fifo.sv
hw/rtl/fn_div.sv
hw/rtl/fn_back.sv
hw/rtl/feature_normalizer.sv
sim/feature_normalizer_test.sv
